// ===== sv/ehd_pkg.sv =====
`default_nettype none

package ehd_pkg;

    // Input field and accumulator sizes
    localparam int BIN_WIDTH    = 8;
    localparam int IN_BIN_W     = 8;
    localparam int MAX_BINS     = 80;
    localparam int COLUMNS      = 5;
    localparam int LOCAL_WIDTH  = 15;
    localparam int GLOBAL_WIDTH = 12;
    localparam int OUT_WIDTH    = 19;
    localparam int FRAC_BITS    = 4;

    // Weight applied to the global part (5/16 with the four fraction bits)
    localparam int GLOBAL_WEIGHT = 5;
    localparam int WEIGHT_W      = $clog2(GLOBAL_WEIGHT + 1);

    // Derived widths
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int GSUM_W = GLOBAL_WIDTH + ((COLUMNS > 1) ? $clog2(COLUMNS) : 0);
    localparam int LOC_Q_W = LOCAL_WIDTH + FRAC_BITS;
    localparam int GLB_Q_W = GSUM_W + WEIGHT_W;
    localparam int TOT_W   = ((LOC_Q_W > GLB_Q_W) ? LOC_Q_W : GLB_Q_W) + 1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((2 * IN_BIN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    typedef logic [LOCAL_WIDTH-1:0]  t_local;
    typedef logic [GLOBAL_WIDTH-1:0] t_global;
    typedef logic [COL_W-1:0]        t_col;

endpackage

`default_nettype wire

// ===== sv/edge_histogram_distance.sv =====
`default_nettype none

// Edge-histogram distance engine. Each transfer on the slave stream carries one
// bin of each of two descriptors (tdata: first bin in the low byte, second bin in
// the next byte; tlast marks the final bin pair). One bin pair is taken every
// clock cycle unless the capture stage is stalled. Sums of absolute bin
// differences and per-column global sums (column = bin position modulo five)
// saturate at their widths. The transfer marked tlast yields one result,
// 16*local + 5*global, the distance with four fraction bits, saturated to 19
// bits, with tuser set when the bin count was not a multiple of five; all sums
// then restart from zero. A result goes through a capture stage, a stage of
// column differences and the output register that forms the weighted sum. A
// stage moves when the next is free or moving; bins flow while one result waits.
module edge_histogram_distance
    import ehd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [S_TDATA_W-1:0]   i_s_tdata,   // first_bin, second_bin
    input  wire                    i_s_tlast,   // last_bin
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [M_TDATA_W-1:0]   o_m_tdata,   // distance_q4, zero pad
    output logic                   o_m_tuser    // partial_group
);

    // Accumulator state
    t_local  r_local;
    t_col    r_col;
    t_global r_gfirst  [COLUMNS];
    t_global r_gsecond [COLUMNS];

    // Capture stage
    logic    r_s1_vld;
    logic    r_s1_partial;
    t_local  r_s1_local;
    t_global r_s1_gfirst  [COLUMNS];
    t_global r_s1_gsecond [COLUMNS];

    // Difference stage
    logic    r_s2_vld;
    logic    r_s2_partial;
    t_local  r_s2_local;
    t_global r_s2_gdiff [COLUMNS];

    // Output register
    logic                 r_out_vld;
    logic                 r_out_partial;
    logic [OUT_WIDTH-1:0] r_out_dist;

    // Next values
    t_local  n_local;
    t_col    n_col;
    t_global n_gfirst  [COLUMNS];
    t_global n_gsecond [COLUMNS];
    t_global n_gdiff   [COLUMNS];
    logic [OUT_WIDTH-1:0] n_dist;
    logic [GSUM_W-1:0]    n_gsum;
    logic [TOT_W-1:0]     n_total;

    logic [BIN_WIDTH-1:0]      w_a;
    logic [BIN_WIDTH-1:0]      w_b;
    logic [BIN_WIDTH-1:0]      w_adiff;
    logic [LOCAL_WIDTH:0]      w_lsum;
    logic [GLOBAL_WIDTH:0]     w_fsum [COLUMNS];
    logic [GLOBAL_WIDTH:0]     w_ssum [COLUMNS];

    logic w_in_xfer;
    logic w_last_xfer;
    logic w_s1_en;
    logic w_s2_en;
    logic w_s3_en;

    // Stage enables: a stage moves when the one after it is free or moving
    assign w_s3_en     = !r_out_vld || i_m_tready;
    assign w_s2_en     = !r_s2_vld || w_s3_en;
    assign w_s1_en     = !r_s1_vld || w_s2_en;
    assign o_s_tready  = w_s1_en;
    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_last_xfer = w_in_xfer && i_s_tlast;

    assign w_a = i_s_tdata[BIN_WIDTH-1:0];
    assign w_b = i_s_tdata[IN_BIN_W +: BIN_WIDTH];

    // Accumulate one bin pair with saturation
    always_comb begin
        w_adiff = (w_a >= w_b) ? (w_a - w_b) : (w_b - w_a);
        w_lsum  = {1'b0, r_local} + (LOCAL_WIDTH+1)'(w_adiff);
        n_local = w_lsum[LOCAL_WIDTH] ? {LOCAL_WIDTH{1'b1}} : w_lsum[LOCAL_WIDTH-1:0];
        n_col   = (r_col >= COL_LAST) ? '0 : r_col + 1'b1;
        for (int c = 0; c < COLUMNS; c++) begin
            w_fsum[c] = {1'b0, r_gfirst[c]};
            w_ssum[c] = {1'b0, r_gsecond[c]};
            if (r_col == COL_W'(c)) begin
                w_fsum[c] = w_fsum[c] + (GLOBAL_WIDTH+1)'(w_a);
                w_ssum[c] = w_ssum[c] + (GLOBAL_WIDTH+1)'(w_b);
            end
            n_gfirst[c]  = w_fsum[c][GLOBAL_WIDTH] ? {GLOBAL_WIDTH{1'b1}}
                                                   : w_fsum[c][GLOBAL_WIDTH-1:0];
            n_gsecond[c] = w_ssum[c][GLOBAL_WIDTH] ? {GLOBAL_WIDTH{1'b1}}
                                                   : w_ssum[c][GLOBAL_WIDTH-1:0];
        end
    end

    // Hold accumulators; clear after the last bin pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_last_xfer) begin
            r_local <= '0;
            r_col   <= '0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_gfirst[c]  <= '0;
                r_gsecond[c] <= '0;
            end
        end else if (w_in_xfer) begin
            r_local <= n_local;
            r_col   <= n_col;
            for (int c = 0; c < COLUMNS; c++) begin
                r_gfirst[c]  <= n_gfirst[c];
                r_gsecond[c] <= n_gsecond[c];
            end
        end
    end

    // Capture final sums on the last bin pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_vld <= w_last_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_xfer) begin
            r_s1_local   <= n_local;
            r_s1_partial <= (n_col != '0);
            for (int c = 0; c < COLUMNS; c++) begin
                r_s1_gfirst[c]  <= n_gfirst[c];
                r_s1_gsecond[c] <= n_gsecond[c];
            end
        end
    end

    // Column differences
    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            n_gdiff[c] = (r_s1_gfirst[c] >= r_s1_gsecond[c])
                       ? (r_s1_gfirst[c] - r_s1_gsecond[c])
                       : (r_s1_gsecond[c] - r_s1_gfirst[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_vld) begin
            r_s2_local   <= r_s1_local;
            r_s2_partial <= r_s1_partial;
            for (int c = 0; c < COLUMNS; c++) begin
                r_s2_gdiff[c] <= n_gdiff[c];
            end
        end
    end

    // Weighted sum and output saturation
    always_comb begin
        n_gsum = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            n_gsum = n_gsum + GSUM_W'(r_s2_gdiff[c]);
        end
        n_total = (TOT_W'(r_s2_local) << FRAC_BITS)
                + TOT_W'(n_gsum) * TOT_W'(GLOBAL_WEIGHT);
        if (n_total > TOT_W'({OUT_WIDTH{1'b1}})) begin
            n_dist = {OUT_WIDTH{1'b1}};
        end else begin
            n_dist = n_total[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s3_en) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_en && r_s2_vld) begin
            r_out_dist    <= n_dist;
            r_out_partial <= r_s2_partial;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_TDATA_W'(r_out_dist);
    assign o_m_tuser  = r_out_partial;

    // Column counter stays inside the column range
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column index out of range");

    // Last bin pair clears the accumulators
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_xfer |=> (r_local == '0) && (r_col == '0))
        else $error("accumulators not cleared after last bin");

    // Last bin pair always lands in the capture stage
    a_capture_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_xfer |=> r_s1_vld)
        else $error("last bin pair not captured");

    // A stalled result is not overwritten by the stage behind it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> r_out_vld && $stable(r_out_dist))
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== bench/edge_histogram_distance_test.sv =====
module edge_histogram_distance_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ehd_pkg::*;

    localparam int ITEM_TARGET    = 1750;
    localparam int MAX_IDLE       = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 8;
    localparam int unsigned LOCAL_MAX  = (1 << LOCAL_WIDTH) - 1;
    localparam int unsigned GLOBAL_MAX = (1 << GLOBAL_WIDTH) - 1;
    localparam longint unsigned OUT_MAX = (64'd1 << OUT_WIDTH) - 1;

    typedef struct {
        logic [IN_BIN_W-1:0] first_bin;
        logic [IN_BIN_W-1:0] second_bin;
        bit                  last_bin;
        bit                  wait_drain;
    } t_bin_pair;

    typedef struct {
        logic [OUT_WIDTH-1:0] distance_q4;
        bit                   partial_group;
    } t_distance;

    typedef enum {VAL_UNIFORM, VAL_EXTREME, VAL_CLOSE, VAL_MAX_VS_ZERO} t_value_style;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tlast  = 1'b0;
    logic                 i_m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    t_bin_pair pending_pairs[$];
    t_distance expected_distances[$];

    // Predicted accumulator state
    int unsigned sum_local;
    int unsigned col_first[COLUMNS];
    int unsigned col_second[COLUMNS];
    int          col_pos;

    bit s_took;
    bit m_took;
    bit failed;
    int quiet_cycles;
    int send_wait;
    int recv_wait;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;

    edge_histogram_distance dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // first_bin, second_bin
        .i_s_tlast  (i_s_tlast),   // last_bin
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // distance_q4, zero pad
        .o_m_tuser  (o_m_tuser)    // partial_group
    );

    function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned max);
        return (a + b > max) ? max : a + b;
    endfunction

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Fold one bin pair into the sums; on the last pair form the distance and clear
    function automatic bit fold_bin_pair(input logic [IN_BIN_W-1:0] first_bin,
                                         input logic [IN_BIN_W-1:0] second_bin,
                                         input bit last_bin, output t_distance result);
        int unsigned a;
        int unsigned b;
        int unsigned glob_diff;
        longint unsigned total;
        a = first_bin[BIN_WIDTH-1:0];
        b = second_bin[BIN_WIDTH-1:0];
        result = '{default: '0};
        sum_local = sat_add(sum_local, abs_diff(a, b), LOCAL_MAX);
        col_first[col_pos] = sat_add(col_first[col_pos], a, GLOBAL_MAX);
        col_second[col_pos] = sat_add(col_second[col_pos], b, GLOBAL_MAX);
        col_pos = (col_pos + 1 >= COLUMNS) ? 0 : col_pos + 1;
        if (!last_bin) begin
            return 1'b0;
        end
        glob_diff = 0;
        for (int c = 0; c < COLUMNS; c++) begin
            glob_diff += abs_diff(col_first[c], col_second[c]);
        end
        total = (longint'(sum_local) << FRAC_BITS) + longint'(GLOBAL_WEIGHT) * glob_diff;
        if (total > OUT_MAX) begin
            total = OUT_MAX;
        end
        result.distance_q4 = total[OUT_WIDTH-1:0];
        result.partial_group = (col_pos != 0);
        sum_local = 0;
        col_pos = 0;
        for (int c = 0; c < COLUMNS; c++) begin
            col_first[c] = 0;
            col_second[c] = 0;
        end
        return 1'b1;
    endfunction

    task automatic add_pair(int first_bin, int second_bin, bit last_bin, bit wait_drain);
        t_bin_pair pair;
        pair.first_bin = IN_BIN_W'(first_bin);
        pair.second_bin = IN_BIN_W'(second_bin);
        pair.last_bin = last_bin;
        pair.wait_drain = wait_drain;
        pending_pairs.push_back(pair);
    endtask

    // Queue one descriptor pair of n_bins bins, tlast on the final one
    task automatic add_descriptor(int n_bins, t_value_style style, bit wait_drain);
        int a;
        int b;
        for (int i = 0; i < n_bins; i++) begin
            case (style)
                VAL_EXTREME: begin
                    a = $urandom_range(0, 1) ? 255 : 0;
                    b = $urandom_range(0, 1) ? 255 : 0;
                end
                VAL_CLOSE: begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range((a > 4) ? a - 4 : 0, (a < 251) ? a + 4 : 255);
                end
                VAL_MAX_VS_ZERO: begin
                    a = 255;
                    b = 0;
                end
                default: begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
            endcase
            add_pair(a, b, i == n_bins - 1, wait_drain && i == 0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sender: offer the next bin pair after a random gap, hold it until taken
    always @(negedge i_clk) begin
        t_bin_pair pair;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !s_took) begin
            // hold the current transfer
        end else if (send_wait != 0) begin
            send_wait--;
            i_s_tvalid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].wait_drain && expected_distances.size() != 0)) begin
            pair = pending_pairs.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata <= S_TDATA_W'({pair.second_bin, pair.first_bin});
            i_s_tlast <= pair.last_bin;
            if ($urandom_range(0, 63) == 0) begin
                send_idle = !send_idle;
            end
            send_wait = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Receiver: in its idle mode, stall for a random gap after each result and now and then at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (m_took) begin
                if ($urandom_range(0, 15) == 0) begin
                    recv_idle = !recv_idle;
                end
                recv_wait = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (recv_wait == 0 && recv_idle && $urandom_range(0, 7) == 0) begin
                recv_wait = $urandom_range(0, MAX_IDLE);
            end
            if (recv_wait != 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: check result transfers, predict from bin pair transfers
    always @(posedge i_clk) begin
        t_distance want;
        logic [OUT_WIDTH-1:0] got_distance;
        if (!i_rst_n) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= i_s_tvalid && o_s_tready;
            m_took <= o_m_tvalid && i_m_tready;
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got_distance = o_m_tdata[OUT_WIDTH-1:0];
                if (expected_distances.size() == 0) begin
                    $error("unexpected result: distance_q4 %0d partial_group %0d",
                           got_distance, o_m_tuser);
                    failed = 1'b1;
                end else begin
                    want = expected_distances.pop_front();
                    if (got_distance !== want.distance_q4) begin
                        $error("distance_q4: expected %0d, got %0d",
                               want.distance_q4, got_distance);
                        failed = 1'b1;
                    end
                    if (o_m_tuser !== want.partial_group) begin
                        $error("partial_group: expected %0d, got %0d",
                               want.partial_group, o_m_tuser);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[M_TDATA_W-1:OUT_WIDTH] !== '0) begin
                        $error("tdata pad: expected 0, got %0h",
                               o_m_tdata[M_TDATA_W-1:OUT_WIDTH]);
                        failed = 1'b1;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                if (fold_bin_pair(i_s_tdata[IN_BIN_W-1:0], i_s_tdata[2*IN_BIN_W-1:IN_BIN_W],
                                  i_s_tlast, want)) begin
                    expected_distances.push_back(want);
                end
            end
        end
    end

    // Give up when nothing has moved for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n_random;
        int pick;
        t_value_style style;

        // Single bins at the extremes, each one a partial group
        add_pair(255, 0, 1'b1, 1'b0);
        add_pair(0, 255, 1'b1, 1'b0);
        add_pair(0, 0, 1'b1, 1'b0);
        // One full group of maximum differences
        add_descriptor(5, VAL_MAX_VS_ZERO, 1'b0);
        // One full group of mixed values
        add_pair(255, 255, 1'b0, 1'b0);
        add_pair(0, 0, 1'b0, 1'b0);
        add_pair(17, 200, 1'b0, 1'b0);
        add_pair(128, 127, 1'b0, 1'b0);
        add_pair(1, 254, 1'b1, 1'b0);
        // Wrap past the last column and stop one bin into the next group
        add_descriptor(6, VAL_UNIFORM, 1'b1);

        // Random descriptors: mostly short, some full size, a few overlong ones
        n_random = 0;
        while (n_random < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                style = $urandom_range(0, 1) ? VAL_MAX_VS_ZERO : VAL_EXTREME;
                pick = $urandom_range(130, 200);
            end else begin
                style = t_value_style'($urandom_range(0, 3));
                pick = (pick <= 3) ? MAX_BINS : $urandom_range(1, 30);
            end
            add_descriptor(pick, style, $urandom_range(0, 7) == 0);
            n_random += pick;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_s_tvalid || expected_distances.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (!failed && expected_distances.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ehd_pkg.sv
sv/edge_histogram_distance.sv
bench/edge_histogram_distance_test.sv
